[rtl/owrse_pkg.sv]
// Shared types and constants for the 1-Wire search ROM decision engine.
`default_nettype none

package owrse_pkg;

   // Command codes of the request channel.
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_START = 2'd1,
      CMD_BIT   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Status codes of the response channel.
   typedef enum logic [2:0] {
      ST_ACK         = 3'd0,
      ST_BIT         = 3'd1,
      ST_FOUND       = 3'd2,
      ST_COMPLETE    = 3'd3,
      ST_NO_PRESENCE = 3'd4,
      ST_BUS_ERROR   = 3'd5,
      ST_CRC_ERROR   = 3'd6,
      ST_NOT_IN_PASS = 3'd7
   } status_type;

   // Reflected CRC-8 polynomial used by the ROM code check.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Discrepancies below this position lie inside the family code byte.
   localparam int unsigned FAMILY_LIMIT = 9;

   // One request item as held in the input register.
   typedef struct packed {
      logic [1:0] cmd;
      logic       presence;
      logic       id_bit;
      logic       comp_bit;
   } item_type;

   // One response item as produced by the decision logic.
   typedef struct packed {
      logic        write_dir;
      status_type  status;
      logic [63:0] rom_id;
      logic [3:0]  family_discrepancy;
   } result_type;

endpackage

`default_nettype wire

[rtl/owrse_core.sv]
// Search state and per-item decision logic of the search ROM engine.
`default_nettype none

module owrse_core
   import owrse_pkg::*;
#(
   parameter int unsigned ROM_BYTES = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   output result_type      result
);

   localparam int unsigned TOTAL_BITS = ROM_BYTES * 8;
   localparam int unsigned CRC_BITS   = (ROM_BYTES - 1) * 8;
   localparam int unsigned POS_W      = $clog2(TOTAL_BITS + 1);
   localparam int unsigned IDX_W      = $clog2(TOTAL_BITS);

   logic [TOTAL_BITS-1:0] rom_bits_ff, rom_bits_in;
   logic [POS_W-1:0]      last_disc_ff, last_disc_in;
   logic                  last_device_ff, last_device_in;
   logic [3:0]            last_family_ff, last_family_in;
   logic [POS_W-1:0]      bit_number_ff, bit_number_in;
   logic [POS_W-1:0]      last_zero_ff, last_zero_in;
   logic [7:0]            crc_ff, crc_in;
   logic                  active_ff, active_in;

   logic [POS_W-1:0]      bit_m1;
   logic [IDX_W-1:0]      bit_idx;
   logic                  dir;
   logic                  fb;
   logic [63:0]           rom_view;

   assign bit_m1  = bit_number_ff - POS_W'(1);
   assign bit_idx = bit_m1[IDX_W-1:0];

   // The first eight bytes of the updated ROM code, zero padded when shorter.
   if (TOTAL_BITS >= 64) begin : g_rom_wide
      assign rom_view = rom_bits_in[63:0];
   end else begin : g_rom_narrow
      assign rom_view = {{(64 - TOTAL_BITS){1'b0}}, rom_bits_in};
   end

   // Decision for one command and the resulting next search state.
   always_comb begin
      rom_bits_in    = rom_bits_ff;
      last_disc_in   = last_disc_ff;
      last_device_in = last_device_ff;
      last_family_in = last_family_ff;
      bit_number_in  = bit_number_ff;
      last_zero_in   = last_zero_ff;
      crc_in         = crc_ff;
      active_in      = active_ff;
      dir            = 1'b0;
      fb             = 1'b0;
      result.write_dir = 1'b0;
      result.status    = ST_ACK;
      result.rom_id    = '0;

      case (cmd_type'(item.cmd))
         CMD_CLEAR: begin
            rom_bits_in    = '0;
            last_disc_in   = '0;
            last_device_in = 1'b0;
            last_family_in = '0;
            active_in      = 1'b0;
         end
         CMD_START: begin
            if (last_device_ff) begin
               last_device_in = 1'b0;
               active_in      = 1'b0;
               result.status  = ST_COMPLETE;
            end else if (!item.presence) begin
               active_in     = 1'b0;
               result.status = ST_NO_PRESENCE;
            end else begin
               active_in     = 1'b1;
               bit_number_in = POS_W'(1);
               last_zero_in  = '0;
               crc_in        = '0;
            end
         end
         CMD_BIT: begin
            if (!active_ff || bit_number_ff == '0 ||
                bit_number_ff > POS_W'(TOTAL_BITS)) begin
               result.status = ST_NOT_IN_PASS;
            end else if (item.id_bit && item.comp_bit) begin
               active_in     = 1'b0;
               result.status = ST_BUS_ERROR;
            end else begin
               // Pick the direction: common bit, or walk the tree on a discrepancy.
               if (item.id_bit != item.comp_bit) begin
                  dir = item.id_bit;
               end else begin
                  if (bit_number_ff < last_disc_ff) begin
                     dir = rom_bits_ff[bit_idx];
                  end else begin
                     dir = (bit_number_ff == last_disc_ff);
                  end
                  if (!dir) begin
                     last_zero_in = bit_number_ff;
                     if (bit_number_ff < POS_W'(FAMILY_LIMIT)) begin
                        last_family_in = bit_number_ff[3:0];
                     end
                  end
               end
               rom_bits_in[bit_idx] = dir;

               // Serial CRC over every byte but the last.
               if (bit_number_ff <= POS_W'(CRC_BITS)) begin
                  fb     = crc_ff[0] ^ dir;
                  crc_in = (crc_ff >> 1) ^ (fb ? CRC_POLY : 8'h00);
               end

               result.write_dir = dir;
               if (bit_number_ff < POS_W'(TOTAL_BITS)) begin
                  bit_number_in = bit_number_ff + POS_W'(1);
                  result.status = ST_BIT;
               end else begin
                  // Final bit: close the pass and check the CRC byte.
                  active_in     = 1'b0;
                  bit_number_in = POS_W'(1);
                  if (crc_in != rom_bits_in[TOTAL_BITS-1 -: 8]) begin
                     result.status = ST_CRC_ERROR;
                  end else begin
                     last_disc_in    = last_zero_in;
                     last_device_in  = (last_zero_in == '0);
                     result.status   = ST_FOUND;
                     result.rom_id   = rom_view;
                  end
               end
            end
         end
         default: begin
            result.status = ST_ACK;
         end
      endcase

      result.family_discrepancy = last_family_in;
   end

   // Search state registers, updated once per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bits_ff    <= '0;
         last_disc_ff   <= '0;
         last_device_ff <= 1'b0;
         last_family_ff <= '0;
         bit_number_ff  <= POS_W'(1);
         last_zero_ff   <= '0;
         crc_ff         <= '0;
         active_ff      <= 1'b0;
      end else if (step) begin
         rom_bits_ff    <= rom_bits_in;
         last_disc_ff   <= last_disc_in;
         last_device_ff <= last_device_in;
         last_family_ff <= last_family_in;
         bit_number_ff  <= bit_number_in;
         last_zero_ff   <= last_zero_in;
         crc_ff         <= crc_in;
         active_ff      <= active_in;
      end
   end

endmodule

`default_nettype wire

[rtl/onewire_rom_search_engine_top.sv]
// Top level of the 1-Wire search ROM decision engine with its channel registers.
`default_nettype none

// Each request (clear, start pass, or one observed bit pair) produces exactly one
// response, in order. A request is captured in an input register, decided by short
// logic against the search state, and lands in the response register when that
// register is free or draining; one request can be taken every clock cycle while
// the response side does not stall. rsp_valid rises once the response register is
// loaded. Throughput is bounded only by the response side: while a response
// waits in the response register under rsp_stall, at most one more request is
// taken into the input register before req_stall rises.

module onewire_rom_search_engine_top
   import owrse_pkg::*;
#(
   parameter int unsigned ROM_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic        req_presence,
   input  wire logic        req_id_bit,
   input  wire logic        req_comp_bit,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_write_dir,
   output      logic [2:0]  rsp_status,
   output      logic [63:0] rsp_rom_id,
   output      logic [3:0]  rsp_family_discrepancy
);

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       advance;
   logic       req_take;

   // The input register moves on when the response register is free or draining.
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   owrse_core #(
      .ROM_BYTES (ROM_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .result (result)
   );

   // Control flags of both channel registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of the input register and the response register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.cmd      <= req_cmd;
         s1_item_ff.presence <= req_presence;
         s1_item_ff.id_bit   <= req_id_bit;
         s1_item_ff.comp_bit <= req_comp_bit;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_write_dir          = out_ff.write_dir;
   assign rsp_status             = out_ff.status;
   assign rsp_rom_id             = out_ff.rom_id;
   assign rsp_family_discrepancy = out_ff.family_discrepancy;

endmodule

`default_nettype wire

[rtl/owrse_checker.sv]
// Port-level assertions for the search ROM engine and their bind to the top level.
`default_nettype none

module owrse_port_checker
   import owrse_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_write_dir,
   input wire logic [2:0]  rsp_status,
   input wire logic [63:0] rsp_rom_id,
   input wire logic [3:0]  rsp_family_discrepancy
);

   // A ROM code is shown only with a found response.
   a_rom_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FOUND) |-> rsp_rom_id == 64'd0)
      else $error("ROM code shown without a found status");

   // A direction bit is driven only for responses to a decided bit pair.
   a_dir_only_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_BIT && rsp_status != ST_FOUND &&
       rsp_status != ST_CRC_ERROR) |-> !rsp_write_dir)
      else $error("Direction bit set on a response without a decision");

   // The family discrepancy never points past the family code byte.
   a_family_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_family_discrepancy <= 4'd8)
      else $error("Family discrepancy out of range");

   // A stalled response holds its status until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("Stalled response changed");

   // The request side stalls only behind a stalled response.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("Request stalled while the response side is free");

endmodule

bind onewire_rom_search_engine_top owrse_port_checker u_owrse_port_checker (.*);

`default_nettype wire
